// ===== sv/cnef_pkg.sv =====
// Package for the channel noise event filter: widths, register indexes,
// reset values and the struct types passed between the pipeline modules.
// No dependencies.
package cnef_pkg;

  // Field widths
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned RMS_W      = 16;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Default saturation point of the suspect tallies
  localparam int unsigned MAX_CHANNELS_DEF = 4096;

  // 0.5 in Q1.15
  localparam logic [FRAC_W-1:0] HALF_Q15 = 16'd16384;

  // Register reset values
  localparam logic [FRAC_W-1:0] EVEN_HIGH_RST  = 16'd19661;
  localparam logic [FRAC_W-1:0] EVEN_LOW_RST   = 16'd13107;
  localparam logic [CNT_W-1:0]  EVEN_LIMIT_RST = 13'd10;
  localparam logic [RMS_W-1:0]  RMS_CUT_RST    = 16'd17600;
  localparam logic [CNT_W-1:0]  RMS_LIMIT_RST  = 13'd50;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EVEN_HIGH  = 3'd0,
    REG_EVEN_LOW   = 3'd1,
    REG_EVEN_LIMIT = 3'd2,
    REG_RMS_CUT    = 3'd3,
    REG_RMS_LIMIT  = 3'd4,
    REG_KEEP_EMPTY = 3'd5,
    REG_SKIP_BAD   = 3'd6
  } cfg_idx_e;

  // Current configuration
  typedef struct packed {
    logic [FRAC_W-1:0] even_high;
    logic [FRAC_W-1:0] even_low;
    logic [CNT_W-1:0]  even_limit;
    logic [RMS_W-1:0]  rms_cut;
    logic [CNT_W-1:0]  rms_limit;
    logic              keep_empty;
    logic              skip_bad;
  } cfg_t;

  // One channel item after the product stage
  typedef struct packed {
    logic              last;
    logic              empty;
    logic              counted;    // not skipped as a bad channel
    logic              even_hit;   // even fraction outside the band
    logic              rms_over;   // rms above the cut
    logic              diag_en;    // diagonal cut applies
    logic [PROD_W-1:0] prod_span;  // rms * (hi - lo)
    logic [PROD_W-1:0] prod_dev;   // |ef - 0.5| * rms_cut
    logic [PROD_W-1:0] prod_rhs;   // rms_cut * (hi - lo)
  } stage_t;

endpackage

// ===== sv/cnef_cfg_regs.sv =====
// Configuration register file of the channel noise event filter.
// Depends on cnef_pkg.
module cnef_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cnef_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cnef_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output cnef_pkg::cfg_t                    cfg_o
);

  cnef_pkg::cfg_t cfg_q, cfg_d;

  // Decode a write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cnef_pkg::cfg_idx_e'(cfg_idx_i))
        cnef_pkg::REG_EVEN_HIGH:  cfg_d.even_high  = cfg_wdata_i;
        cnef_pkg::REG_EVEN_LOW:   cfg_d.even_low   = cfg_wdata_i;
        cnef_pkg::REG_EVEN_LIMIT: cfg_d.even_limit = cfg_wdata_i[cnef_pkg::CNT_W-1:0];
        cnef_pkg::REG_RMS_CUT:    cfg_d.rms_cut    = cfg_wdata_i;
        cnef_pkg::REG_RMS_LIMIT:  cfg_d.rms_limit  = cfg_wdata_i[cnef_pkg::CNT_W-1:0];
        cnef_pkg::REG_KEEP_EMPTY: cfg_d.keep_empty = cfg_wdata_i[0];
        cnef_pkg::REG_SKIP_BAD:   cfg_d.skip_bad   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.even_high  <= cnef_pkg::EVEN_HIGH_RST;
      cfg_q.even_low   <= cnef_pkg::EVEN_LOW_RST;
      cfg_q.even_limit <= cnef_pkg::EVEN_LIMIT_RST;
      cfg_q.rms_cut    <= cnef_pkg::RMS_CUT_RST;
      cfg_q.rms_limit  <= cnef_pkg::RMS_LIMIT_RST;
      cfg_q.keep_empty <= 1'b1;
      cfg_q.skip_bad   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/cnef_stat_stage.sv =====
// Input register and product stage: band and rms compares plus the three
// products of the diagonal cut, registered for the tally stage.
// Depends on cnef_pkg.
module cnef_stat_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cnef_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cnef_pkg::FRAC_W-1:0]    even_ratio_i,
  input  logic [cnef_pkg::RMS_W-1:0]     rms_value_i,
  input  logic                           channel_bad_i,
  input  logic                           last_channel_i,
  input  logic                           empty_event_i,
  output logic                           stage_valid_o,
  input  logic                           stage_ready_i,
  output cnef_pkg::stage_t               stage_o
);

  // Input register
  logic                        in_v_q;
  logic [cnef_pkg::FRAC_W-1:0] ef_q;
  logic [cnef_pkg::RMS_W-1:0]  rms_q;
  logic                        bad_q, last_q, empty_q;

  // Product register
  logic             st_v_q;
  cnef_pkg::stage_t st_q, st_d;

  logic                        st_free, in_adv, in_free;
  logic [cnef_pkg::FRAC_W-1:0] span, dev;

  // Handshake between the two registers
  assign st_free    = !st_v_q || stage_ready_i;
  assign in_adv     = in_v_q && st_free;
  assign in_free    = !in_v_q || in_adv;
  assign in_stall_o = !in_free;

  // Compares and products for the item held in the input register
  always_comb begin
    span = cfg_i.even_high - cfg_i.even_low;
    dev  = (ef_q >= cnef_pkg::HALF_Q15) ? (ef_q - cnef_pkg::HALF_Q15)
                                        : (cnef_pkg::HALF_Q15 - ef_q);
    st_d.last      = last_q;
    st_d.empty     = empty_q;
    st_d.counted   = !(cfg_i.skip_bad && bad_q);
    st_d.even_hit  = (ef_q > cfg_i.even_high) || (ef_q < cfg_i.even_low);
    st_d.rms_over  = rms_q > cfg_i.rms_cut;
    st_d.diag_en   = (cfg_i.rms_cut != '0) && (cfg_i.even_high > cfg_i.even_low);
    st_d.prod_span = cnef_pkg::PROD_W'(rms_q) * cnef_pkg::PROD_W'(span);
    st_d.prod_dev  = cnef_pkg::PROD_W'(dev) * cnef_pkg::PROD_W'(cfg_i.rms_cut);
    st_d.prod_rhs  = cnef_pkg::PROD_W'(cfg_i.rms_cut) * cnef_pkg::PROD_W'(span);
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      st_v_q <= 1'b0;
    end else begin
      if (in_free) in_v_q <= in_valid_i;
      if (st_free) st_v_q <= in_adv;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      ef_q    <= even_ratio_i;
      rms_q   <= rms_value_i;
      bad_q   <= channel_bad_i;
      last_q  <= last_channel_i;
      empty_q <= empty_event_i;
    end
    if (in_adv) st_q <= st_d;
  end

  assign stage_valid_o = st_v_q;
  assign stage_o       = st_q;

endmodule

// ===== sv/cnef_tally.sv =====
// Tally stage: finishes the diagonal cut, keeps the saturating suspect
// counts and holds the per-event result register.
// Depends on cnef_pkg.
module cnef_tally #(
  parameter int unsigned MAX_CHANNELS = cnef_pkg::MAX_CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cnef_pkg::cfg_t               cfg_i,
  input  logic                         stage_valid_i,
  output logic                         stage_ready_o,
  input  cnef_pkg::stage_t             stage_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         keep_event_o,
  output logic [cnef_pkg::CNT_W-1:0]   even_suspect_count_o,
  output logic [cnef_pkg::CNT_W-1:0]   rms_suspect_count_o
);

  localparam logic [cnef_pkg::CNT_W-1:0] MaxCnt = cnef_pkg::CNT_W'(MAX_CHANNELS);
  localparam int unsigned LhsW = cnef_pkg::PROD_W + 2;

  function automatic logic [cnef_pkg::CNT_W-1:0] bump(
    input logic [cnef_pkg::CNT_W-1:0] n
  );
    return (n < MaxCnt) ? n + cnef_pkg::CNT_W'(1) : MaxCnt;
  endfunction

  logic [cnef_pkg::CNT_W-1:0] even_q, rms_q, even_new, rms_new;
  logic                       out_v_q, keep_q;
  logic [cnef_pkg::CNT_W-1:0] even_out_q, rms_out_q;

  logic            out_free, has_res, adv;
  logic [LhsW-1:0] lhs;
  logic            rms_hit;

  // Items without a result never wait on the output register
  assign out_free      = !out_v_q || !out_stall_i;
  assign has_res       = stage_i.last || stage_i.empty;
  assign adv           = stage_valid_i && (!has_res || out_free);
  assign stage_ready_o = !has_res || out_free;

  // Diagonal cut: rms*span + 2*dev*cut > cut*span
  always_comb begin
    lhs     = LhsW'(stage_i.prod_span) + LhsW'({stage_i.prod_dev, 1'b0});
    rms_hit = stage_i.rms_over ||
              (stage_i.diag_en && (lhs > LhsW'(stage_i.prod_rhs)));
    even_new = (stage_i.counted && stage_i.even_hit) ? bump(even_q) : even_q;
    rms_new  = (stage_i.counted && rms_hit) ? bump(rms_q) : rms_q;
  end

  // Control: tallies and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_q  <= '0;
      rms_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        if (has_res) begin
          even_q <= '0;
          rms_q  <= '0;
        end else begin
          even_q <= even_new;
          rms_q  <= rms_new;
        end
      end
      if (out_free) out_v_q <= adv && has_res;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (adv && has_res) begin
      if (stage_i.empty) begin
        keep_q     <= cfg_i.keep_empty;
        even_out_q <= '0;
        rms_out_q  <= '0;
      end else begin
        keep_q     <= (even_new <= cfg_i.even_limit) && (rms_new <= cfg_i.rms_limit);
        even_out_q <= even_new;
        rms_out_q  <= rms_new;
      end
    end
  end

  assign out_valid_o          = out_v_q;
  assign keep_event_o         = keep_q;
  assign even_suspect_count_o = even_out_q;
  assign rms_suspect_count_o  = rms_out_q;

endmodule

// ===== sv/channel_noise_event_filter.sv =====
// Top level of the channel noise event filter.
// Depends on cnef_pkg, cnef_cfg_regs, cnef_stat_stage and cnef_tally.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  even_ratio, rms_value, channel_bad,
//                                              last_channel, empty_event
//   out      output     out_valid_o/out_stall_i keep_event, even_suspect_count,
//                                              rms_suspect_count
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One channel item is accepted every cycle while in_stall_o is low. The item ending
// its event (last channel or empty event) passes the input register, the product
// register and the result register before out_valid_o rises.
// Reset clears the valid flags and both tallies and loads the register defaults.
// A stalled result holds; items that end no event keep flowing into the
// tallies while it waits, and input stalls only when a result backs up.
module channel_noise_event_filter #(
  parameter int unsigned MAX_CHANNELS = cnef_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cnef_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cnef_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [cnef_pkg::FRAC_W-1:0]      even_ratio_i,
  input  logic [cnef_pkg::RMS_W-1:0]       rms_value_i,
  input  logic                             channel_bad_i,
  input  logic                             last_channel_i,
  input  logic                             empty_event_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             keep_event_o,
  output logic [cnef_pkg::CNT_W-1:0]       even_suspect_count_o,
  output logic [cnef_pkg::CNT_W-1:0]       rms_suspect_count_o
);

  cnef_pkg::cfg_t   cfg;
  cnef_pkg::stage_t stage;
  logic             stage_valid, stage_ready;

  cnef_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cnef_stat_stage u_stat (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .even_ratio_i    (even_ratio_i),
    .rms_value_i     (rms_value_i),
    .channel_bad_i   (channel_bad_i),
    .last_channel_i  (last_channel_i),
    .empty_event_i   (empty_event_i),
    .stage_valid_o   (stage_valid),
    .stage_ready_i   (stage_ready),
    .stage_o         (stage)
  );

  cnef_tally #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_tally (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .stage_valid_i        (stage_valid),
    .stage_ready_o        (stage_ready),
    .stage_i              (stage),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .keep_event_o         (keep_event_o),
    .even_suspect_count_o (even_suspect_count_o),
    .rms_suspect_count_o  (rms_suspect_count_o)
  );

endmodule

// ===== sv/cnef_checker.sv =====
// Port-level checks for the channel noise event filter, bound to the top level.
// Depends on cnef_pkg and channel_noise_event_filter.
module cnef_checker #(
  parameter int unsigned MAX_CHANNELS = cnef_pkg::MAX_CHANNELS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         keep_event_o,
  input logic [cnef_pkg::CNT_W-1:0]   even_suspect_count_o,
  input logic [cnef_pkg::CNT_W-1:0]   rms_suspect_count_o
);

  localparam logic [cnef_pkg::CNT_W-1:0] MaxCnt = cnef_pkg::CNT_W'(MAX_CHANNELS);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An empty result register never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result pending");

  // Counts never pass the saturation point
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (even_suspect_count_o <= MaxCnt) && (rms_suspect_count_o <= MaxCnt))
    else $error("suspect count above saturation");

  // A stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(keep_event_o) &&
      $stable(even_suspect_count_o) && $stable(rms_suspect_count_o))
    else $error("stalled result changed");

endmodule

bind channel_noise_event_filter cnef_checker #(
  .MAX_CHANNELS (MAX_CHANNELS)
) u_cnef_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .keep_event_o         (keep_event_o),
  .even_suspect_count_o (even_suspect_count_o),
  .rms_suspect_count_o  (rms_suspect_count_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for channel_noise_event_filter: directed channel table, then
// randomized events under several register settings, with random input gaps and output stalls.
// Depends on cnef_pkg and the channel_noise_event_filter RTL.
module tb_top;
  import cnef_pkg::*;

  localparam int unsigned MAX_CH = MAX_CHANNELS_DEF;

  // One channel item as it goes into the block
  typedef struct packed {
    logic [FRAC_W-1:0] even_ratio;
    logic [RMS_W-1:0]  rms_value;
    logic              channel_bad;
    logic              last_channel;
    logic              empty_event;
  } channel_t;

  // One event decision as it comes out
  typedef struct packed {
    logic             keep;
    logic [CNT_W-1:0] even_cnt;
    logic [CNT_W-1:0] rms_cnt;
  } decision_t;

  // Directed row: channel, whether the decision is typed in, and that decision
  typedef struct packed {
    channel_t  chan;
    logic      typed;
    decision_t want;
  } dir_row_t;

  // Directed channels, run under the reset settings
  localparam dir_row_t DIR_ROWS [16] = '{
    // empty event, all other fields at their maximum
    '{'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b1, 13'd0, 13'd0}},
    // centered fraction, zero rms: clean one-channel event
    '{'{16'd16384, 16'd0, 1'b0, 1'b1, 1'b0}, 1'b1, '{1'b1, 13'd0, 13'd0}},
    // zero fraction, full rms: both suspect, still within limits
    '{'{16'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0}, 1'b1, '{1'b1, 13'd1, 13'd1}},
    // fraction above range, then a skipped bad channel, then band edges
    '{'{16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd32768, 16'd17600, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd19661, 16'd17600, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    // low edge with zero rms sits exactly on the diagonal line
    '{'{16'd13107, 16'd0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    // bad last channel with skipping on still closes the event
    '{'{16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 13'd0, 13'd0}},
    // partial event dropped by an empty event
    '{'{16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'h1234, 16'h5678, 1'b0, 1'b0, 1'b1}, 1'b1, '{1'b1, 13'd0, 13'd0}},
    // one step past the cuts
    '{'{16'd16385, 16'd17601, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{16'd13106, 16'd17600, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{16'd19662, 16'd1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd32768, 16'hFFFF, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0}, 1'b0, '0}
  };

  // Corner settings: widest band, inverted band, zero-width band
  localparam cfg_t CORNER_CFGS [3] = '{
    '{even_high: 16'hFFFF, even_low: 16'h0000, even_limit: 13'd0, rms_cut: 16'hFFFF,
      rms_limit: 13'd0, keep_empty: 1'b0, skip_bad: 1'b0},
    '{even_high: 16'h0000, even_low: 16'hFFFF, even_limit: 13'h1FFF, rms_cut: 16'h0000,
      rms_limit: 13'h1FFF, keep_empty: 1'b1, skip_bad: 1'b1},
    '{even_high: 16'd16384, even_low: 16'd16384, even_limit: 13'd1, rms_cut: 16'd1,
      rms_limit: 13'd1, keep_empty: 1'b0, skip_bad: 1'b0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [FRAC_W-1:0]     even_ratio_i;
  logic [RMS_W-1:0]      rms_value_i;
  logic                  channel_bad_i;
  logic                  last_channel_i;
  logic                  empty_event_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  keep_event_o;
  logic [CNT_W-1:0]      even_suspect_count_o;
  logic [CNT_W-1:0]      rms_suspect_count_o;

  // Predictor state: register copy and both tallies
  cfg_t             cur_cfg;
  logic [CNT_W-1:0] even_tally;
  logic [CNT_W-1:0] rms_tally;

  decision_t   due_decisions [$];
  int unsigned fail_count = 0;
  bit          gap_on = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned stall_left = 0;

  channel_noise_event_filter #(
    .MAX_CHANNELS(MAX_CH)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .even_ratio_i        (even_ratio_i),
    .rms_value_i         (rms_value_i),
    .channel_bad_i       (channel_bad_i),
    .last_channel_i      (last_channel_i),
    .empty_event_i       (empty_event_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .keep_event_o        (keep_event_o),
    .even_suspect_count_o(even_suspect_count_o),
    .rms_suspect_count_o (rms_suspect_count_o)
  );

  // Clock, period 8
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] n);
    return (n < MAX_CH) ? n + 13'd1 : CNT_W'(MAX_CH);
  endfunction

  // Tally one channel; returns 1 with the decision when the item closes an event
  function automatic bit filter_channel(input channel_t ch, output decision_t dec);
    logic [63:0] span;
    logic [63:0] dev;
    logic [63:0] lhs;
    logic [63:0] rhs;
    bit          diag;
    dec = '0;
    if (ch.empty_event) begin
      even_tally = '0;
      rms_tally = '0;
      dec.keep = cur_cfg.keep_empty;
      return 1'b1;
    end
    if (!(cur_cfg.skip_bad && ch.channel_bad)) begin
      if (ch.even_ratio > cur_cfg.even_high || ch.even_ratio < cur_cfg.even_low) begin
        even_tally = bump(even_tally);
      end
      // diagonal cut, all terms at full width
      span = 64'(cur_cfg.even_high) - 64'(cur_cfg.even_low);
      dev = (ch.even_ratio >= HALF_Q15) ? 64'(ch.even_ratio) - 64'(HALF_Q15)
                                        : 64'(HALF_Q15) - 64'(ch.even_ratio);
      lhs = 64'(ch.rms_value) * span + 64'd2 * dev * 64'(cur_cfg.rms_cut);
      rhs = 64'(cur_cfg.rms_cut) * span;
      diag = (cur_cfg.rms_cut != '0) && (cur_cfg.even_high > cur_cfg.even_low) && (lhs > rhs);
      if (ch.rms_value > cur_cfg.rms_cut || diag) begin
        rms_tally = bump(rms_tally);
      end
    end
    if (!ch.last_channel) begin
      return 1'b0;
    end
    dec.keep = (even_tally <= cur_cfg.even_limit) && (rms_tally <= cur_cfg.rms_limit);
    dec.even_cnt = even_tally;
    dec.rms_cnt = rms_tally;
    even_tally = '0;
    rms_tally = '0;
    return 1'b1;
  endfunction

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gap_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Fractions cluster on the band edges and the center, with some full-range noise
  function automatic logic [FRAC_W-1:0] pick_frac();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return 16'(($urandom_range(0, 1) ? cur_cfg.even_high : cur_cfg.even_low)
                 + $urandom_range(0, 6) - 3);
    end else if (r < 7) begin
      return 16'($urandom_range(0, 32768));
    end else if (r == 7) begin
      return 16'($urandom);
    end else if (r == 8) begin
      return 16'(HALF_Q15 + $urandom_range(0, 6) - 3);
    end
    case ($urandom_range(0, 2))
      0: return 16'd0;
      1: return 16'd32768;
      default: return 16'hFFFF;
    endcase
  endfunction

  // RMS clusters on the cut and inside the diagonal region
  function automatic logic [RMS_W-1:0] pick_rms();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return 16'(cur_cfg.rms_cut + $urandom_range(0, 6) - 3);
    end else if (r < 6) begin
      return 16'($urandom_range(0, cur_cfg.rms_cut));
    end else if (r < 8) begin
      return 16'($urandom);
    end else if (r == 8) begin
      return 16'($urandom_range(0, 255));
    end
    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    if ($urandom_range(0, 4) != 0) begin
      s.even_low = 16'(16384 - $urandom_range(0, 16384));
      s.even_high = 16'(16384 + $urandom_range(0, 16384));
    end else begin
      s.even_low = 16'($urandom);
      s.even_high = 16'($urandom);
    end
    s.even_limit = ($urandom_range(0, 3) != 0) ? 13'($urandom_range(0, 6)) : 13'($urandom);
    s.rms_cut = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 30000)) : 16'($urandom);
    s.rms_limit = ($urandom_range(0, 3) != 0) ? 13'($urandom_range(0, 6)) : 13'($urandom);
    s.keep_empty = 1'($urandom);
    s.skip_bad = 1'($urandom);
    return s;
  endfunction

  // Offer one channel, hold it until taken, then predict
  task automatic send_item(input channel_t ch, input bit typed, input decision_t want);
    int unsigned gap;
    decision_t   dec;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    even_ratio_i <= ch.even_ratio;
    rms_value_i <= ch.rms_value;
    channel_bad_i <= ch.channel_bad;
    last_channel_i <= ch.last_channel;
    empty_event_i <= ch.empty_event;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (filter_channel(ch, dec)) begin
      due_decisions.push_back(typed ? want : dec);
    end
  endtask

  // Wait for all decisions plus the pipeline depth, so tallies are settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_decisions.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Write all registers; unused upper data bits carry noise
  task automatic apply_settings(input cfg_t s);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_EVEN_HIGH, s.even_high);
    write_reg(REG_EVEN_LOW, s.even_low);
    write_reg(REG_EVEN_LIMIT, {junk[15:13], s.even_limit});
    write_reg(REG_RMS_CUT, s.rms_cut);
    write_reg(REG_RMS_LIMIT, {junk[2:0], s.rms_limit});
    write_reg(REG_KEEP_EMPTY, {junk[15:1], s.keep_empty});
    write_reg(REG_SKIP_BAD, {junk[14:0], s.skip_bad});
    cfg_we_i <= 1'b0;
    cur_cfg = s;
  endtask

  // Random events: mostly short, some long, with stray empties and flipped last flags
  task automatic run_events(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    channel_t    ch;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 6) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 60);
      for (int unsigned i = 0; i < len; i++) begin
        ch.even_ratio = pick_frac();
        ch.rms_value = pick_rms();
        ch.channel_bad = ($urandom_range(0, 6) == 0);
        ch.last_channel = (i == len - 1);
        if ($urandom_range(0, 29) == 0) begin
          ch.last_channel = ~ch.last_channel;
        end
        ch.empty_event = ($urandom_range(0, 39) == 0);
        send_item(ch, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Output stall: short bursts, occasional long holds, none in quiet phases
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2) : $urandom_range(8, 40);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each taken decision against the oldest one due
  always @(posedge clk_i) begin : check_decisions
    decision_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (due_decisions.size() == 0) begin
        note_failure($sformatf("decision with none due: keep=%0d even=%0d rms=%0d",
                               keep_event_o, even_suspect_count_o, rms_suspect_count_o));
      end else begin
        want = due_decisions.pop_front();
        if (keep_event_o !== want.keep) begin
          note_failure($sformatf("keep_event exp %0d got %0d", want.keep, keep_event_o));
        end
        if (even_suspect_count_o !== want.even_cnt) begin
          note_failure($sformatf("even_suspect_count exp %0d got %0d",
                                 want.even_cnt, even_suspect_count_o));
        end
        if (rms_suspect_count_o !== want.rms_cnt) begin
          note_failure($sformatf("rms_suspect_count exp %0d got %0d",
                                 want.rms_cnt, rms_suspect_count_o));
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    cfg_t     s;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_EVEN_HIGH;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    even_ratio_i = '0;
    rms_value_i = '0;
    channel_bad_i = 1'b0;
    last_channel_i = 1'b0;
    empty_event_i = 1'b0;
    cur_cfg = '{even_high: EVEN_HIGH_RST, even_low: EVEN_LOW_RST, even_limit: EVEN_LIMIT_RST,
                rms_cut: RMS_CUT_RST, rms_limit: RMS_LIMIT_RST, keep_empty: 1'b1,
                skip_bad: 1'b1};
    even_tally = '0;
    rms_tally = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, then random events, under the reset settings
    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      send_item(DIR_ROWS[i].chan, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
    run_events(200);

    // corner settings first, then random ones
    for (int p = 0; p < 8; p++) begin
      s = (p < 3) ? CORNER_CFGS[p] : random_settings();
      drain();
      apply_settings(s);
      gap_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      run_events((p < 3) ? 150 : 230);
    end
    drain();

    if (fail_count == 0 && due_decisions.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_400_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
